// ===== design/lsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types, constants and helpers for the least-squares line fit block.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // One input word: a point and its end-of-set mark
  typedef struct packed {
    logic [11:0] x_value;
    logic [23:0] y_value;
    logic        last_point;
  } lsf_in_t;

  // One result word: a fitted value and the fit that produced it
  typedef struct packed {
    logic        [11:0] point_x;
    logic signed [47:0] fitted_value;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic               degenerate;
    logic               dropped;
    logic               run_end;
  } lsf_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PROD,
    ST_DIFF,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_PRODB,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_READ,
    ST_MUL,
    ST_PUSH
  } lsf_state_t;

  // Clamp a 64-bit signed value into the signed 48-bit range
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) begin
      sat48 = hi[47:0];
    end else if (v < lo) begin
      sat48 = lo[47:0];
    end else begin
      sat48 = v[47:0];
    end
  endfunction

endpackage

// ===== design/linear_least_squares_fit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_least_squares_fit_top
// Least-squares straight-line fit over a set of points.
//
// Input channel (in_valid/in_stall/in_data) takes one point word per cycle
// while loading: x as a 12-bit integer, y in Q16.8 and a last mark. Up to
// 64 points are held; later ones are discarded and reported through the
// dropped flag. A word with the last mark starts the fit. Input is stalled
// for the whole fit and result phase: two 64-step serial divisions (slope,
// then intercept), or only the intercept division when the denominator is
// not positive, then per stored point an x memory read, a slope multiply
// and a push.
// Output channel (out_valid/out_stall/out_data) gives one word per stored
// point, in arrival order, run_end on the final one. While the receiver
// stalls, the output register holds its word and emission waits.
// After the final result is pushed all sums and flags clear and loading
// resumes. Reset clears the sums, the count and the control state; the x
// memory contents are not cleared, only entries of the current set are read.
// ----------------------------------------------------------------------------
module linear_least_squares_fit_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lsf_pkg::lsf_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lsf_pkg::lsf_out_t out_data
);

  import lsf_pkg::*;

  lsf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [17:0]       sx_r;
  logic [29:0]       sxx_r;
  logic [29:0]       sy_r;
  logic [41:0]       sxy_r;
  logic              ovf_r;

  logic [36:0]         p_nsxx_r;
  logic [35:0]         p_sxsx_r;
  logic [48:0]         p_nsxy_r;
  logic [47:0]         p_sxsy_r;
  logic signed [37:0]  den_r;
  logic signed [49:0]  num_r;
  logic                degen_r;
  logic signed [63:0]  a_r;
  logic signed [63:0]  b_r;
  logic signed [58:0]  p_asx_r;
  logic signed [52:0]  p_ax_r;
  logic [11:0]         px_r;
  logic [ADDR_W-1:0]   idx_r;

  logic              out_valid_r;
  lsf_out_t          out_data_r;

  logic              accept;
  logic              has_room;
  logic              ram_we;
  logic [11:0]       ram_rdata;
  logic              div_start;
  logic signed [63:0] div_dividend;
  logic [39:0]       div_divisor;
  logic              div_done;
  logic signed [63:0] div_q;
  logic              push_ok;
  logic              last_idx;
  logic signed [63:0] fitted;

  function automatic logic den_nonpos(input logic [36:0] p1, input logic [35:0] p2);
    logic signed [37:0] d;
    d = $signed({1'b0, p1}) - $signed({2'b00, p2});
    den_nonpos = (d <= 0);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign has_room = count_r < CNT_W'(MAX_POINTS);
  assign push_ok  = !out_valid_r || !out_stall;
  assign last_idx = {1'b0, idx_r} == (count_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_data.last_point && (has_room || count_r != '0)) begin
          state_nxt = ST_PROD;
        end
      end
      ST_PROD:      state_nxt = ST_DIFF;
      ST_DIFF:      state_nxt = (den_nonpos(p_nsxx_r, p_sxsx_r)) ? ST_PRODB : ST_DIVA_GO;
      ST_DIVA_GO:   state_nxt = ST_DIVA_WAIT;
      ST_DIVA_WAIT: state_nxt = div_done ? ST_PRODB : ST_DIVA_WAIT;
      ST_PRODB:     state_nxt = ST_DIVB_GO;
      ST_DIVB_GO:   state_nxt = ST_DIVB_WAIT;
      ST_DIVB_WAIT: state_nxt = div_done ? ST_READ : ST_DIVB_WAIT;
      ST_READ:      state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_PUSH;
      ST_PUSH: begin
        if (push_ok) begin
          state_nxt = last_idx ? ST_LOAD : ST_READ;
        end
      end
      default:      state_nxt = ST_LOAD;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall     = (state_r != ST_LOAD);
    ram_we       = accept && has_room;
    div_start    = (state_r == ST_DIVA_GO) || (state_r == ST_DIVB_GO);
    div_dividend = 64'(num_r) <<< 8;
    div_divisor  = 40'($unsigned(den_r));
    if (state_r == ST_DIVB_GO) begin
      div_dividend = $signed(64'(sy_r) << 8) - 64'(p_asx_r);
      div_divisor  = 40'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Accumulate points; clear after the final result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (state_r == ST_PUSH && push_ok && last_idx) begin
      count_r <= '0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (has_room) begin
        count_r <= count_r + 1'b1;
        sx_r    <= sx_r + 18'(in_data.x_value);
        sxx_r   <= sxx_r + 30'(in_data.x_value * in_data.x_value);
        sy_r    <= sy_r + 30'(in_data.y_value);
        sxy_r   <= sxy_r + 42'(in_data.x_value * in_data.y_value);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Fit datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PROD: begin
        p_nsxx_r <= 37'(count_r * sxx_r);
        p_sxsx_r <= 36'(sx_r * sx_r);
        p_nsxy_r <= 49'(count_r * sxy_r);
        p_sxsy_r <= 48'(sx_r * sy_r);
      end
      ST_DIFF: begin
        den_r   <= $signed({1'b0, p_nsxx_r}) - $signed({2'b00, p_sxsx_r});
        num_r   <= $signed({1'b0, p_nsxy_r}) - $signed({2'b00, p_sxsy_r});
        degen_r <= den_nonpos(p_nsxx_r, p_sxsx_r);
        a_r     <= '0;
      end
      ST_DIVA_WAIT: begin
        if (div_done) begin
          a_r <= div_q;
        end
      end
      ST_PRODB: begin
        p_asx_r <= 59'($signed(a_r[39:0]) * $signed({1'b0, sx_r}));
      end
      ST_DIVB_WAIT: begin
        if (div_done) begin
          b_r <= div_q;
        end
        idx_r <= '0;
      end
      ST_MUL: begin
        px_r   <= ram_rdata;
        p_ax_r <= 53'($signed(a_r[39:0]) * $signed({1'b0, ram_rdata}));
      end
      ST_PUSH: begin
        if (push_ok) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign fitted = 64'(p_ax_r) + b_r;

  // Output register: hold while stalled, load one word per push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_PUSH && push_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PUSH && push_ok) begin
      out_data_r.point_x      <= px_r;
      out_data_r.fitted_value <= sat48(fitted);
      out_data_r.slope        <= sat48(a_r);
      out_data_r.intercept    <= sat48(b_r);
      out_data_r.degenerate   <= degen_r;
      out_data_r.dropped      <= ovf_r;
      out_data_r.run_end      <= last_idx;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lsf_ram #(
    .WIDTH(12),
    .DEPTH(MAX_POINTS)
  ) u_xram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_data.x_value),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  lsf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

// ===== design/lsf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lsf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lsf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_div
// Signed-by-positive restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic        [39:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  localparam int STEPS = 64;
  localparam int STEP_W = $clog2(STEPS);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [63:0]       dvd_r;
  logic [40:0]       rem_r;
  logic [39:0]       dvs_r;
  logic              neg_r;

  logic [40:0] rem_shift;
  logic [41:0] diff;
  logic        ge;

  // One restoring step
  always_comb begin
    rem_shift = {rem_r[39:0], dvd_r[63]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs_r};
    ge        = ~diff[41];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load magnitude, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend[63] ? 64'(-dividend) : dividend;
      neg_r <= dividend[63];
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[40:0] : rem_shift;
      dvd_r <= {dvd_r[62:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? 64'(-$signed(dvd_r)) : $signed(dvd_r);

endmodule

// ===== design/lsf_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_chk
// Port-level checks for the line fit block, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lsf_pkg::lsf_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lsf_pkg::lsf_out_t out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Loading continues after a point without the last mark
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last_point |=> !in_stall)
    else $error("input stalled during loading");

  // A last point closes the input for the fit
  a_fit_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_point |=> in_stall)
    else $error("input open after last point");

  // No point taken while a run still has results pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |-> in_stall)
    else $error("point accepted during result phase");

endmodule

bind linear_least_squares_fit_top lsf_chk u_lsf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
